// ===== hw/rtl/hcse_pkg.sv =====
// hcse_pkg: shared types and fixed constants of the halves correlation snr estimator
// used by hcse_finish, halves_correlation_snr_estimator and its checker
`default_nettype none
package hcse_pkg;

    localparam int CFG_W      = 9;
    localparam int HALF_RESET = 32;
    localparam int OUT_W      = 28;

    localparam logic [OUT_W-1:0] SNR_MIN_Q8 = 28'd26;
    localparam logic [OUT_W-1:0] SNR_MAX_Q8 = 28'd256000000;

    // clamp of m at 1 - 2e-5, i.e. 49999/50000
    localparam logic [15:0] CLAMP_NUM   = 16'd50000;
    localparam logic [15:0] CLAMP_DEN   = 16'd49999;
    localparam logic [24:0] CLAMP_SCALE = 25'd25600000;

    typedef struct packed {
        logic signed [63:0] corr_re;
        logic signed [63:0] corr_im;
        logic signed [63:0] energy;
    } acc_t;

    typedef struct packed {
        logic idle;
        logic valid;
    } fin_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/hcse_ram.sv =====
// hcse_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module hcse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/hcse_finish.sv =====
// hcse_finish: sequential evaluation of snr = m/(1-m) from the accumulated sums
// depends on hcse_pkg (acc_t, fin_status_t, clamp and saturation constants)
`default_nettype none
module hcse_finish (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  hcse_pkg::acc_t                 acc,
    input  wire logic                      out_stall,
    output hcse_pkg::fin_status_t          status,
    output logic [hcse_pkg::OUT_W-1:0]     result
);
    import hcse_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_NORM = 4'd1;
    localparam logic [3:0] S_SQR  = 4'd2;
    localparam logic [3:0] S_SUM  = 4'd3;
    localparam logic [3:0] S_ROOT = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_SEL  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_SAT  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    localparam logic [63:0] R_LIMIT = 64'h8000_0000;

    logic [3:0]  state_reg, state_next;
    logic [63:0] r_reg, pr_reg, pi_reg;
    logic [61:0] sq_re_reg, sq_im_reg;
    logic [63:0] x_reg, root_reg, bit_reg;
    logic [5:0]  cnt_reg;
    logic [47:0] p1_reg, p2_reg;
    logic [56:0] p3_reg;
    logic [57:0] num_reg, q_reg;
    logic [32:0] den_reg;
    logic [33:0] rem_reg;
    logic [OUT_W-1:0] result_reg;

    logic [31:0] a;
    logic [63:0] sq_sum, root_try;
    logic [33:0] rem_sh;
    logic        clamp;

    assign a        = root_reg[31:0];
    assign sq_sum   = 64'(sq_re_reg) + 64'(sq_im_reg);
    assign root_try = root_reg + bit_reg;
    assign rem_sh   = {rem_reg[32:0], num_reg[57]};
    assign clamp    = p1_reg >= p2_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (start) state_next = (acc.energy == 64'sd0) ? S_DONE : S_NORM;
            S_NORM: if (r_reg < R_LIMIT) state_next = S_SQR;
            S_SQR:  state_next = S_SUM;
            S_SUM:  state_next = S_ROOT;
            S_ROOT: if (cnt_reg == 6'd31) state_next = S_MUL;
            S_MUL:  state_next = S_SEL;
            S_SEL:  state_next = S_DIV;
            S_DIV:  if (cnt_reg == 6'd57) state_next = S_SAT;
            S_SAT:  state_next = S_DONE;
            S_DONE: if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                r_reg      <= acc.energy;
                pr_reg     <= acc.corr_re[63] ? 64'(-acc.corr_re) : acc.corr_re;
                pi_reg     <= acc.corr_im[63] ? 64'(-acc.corr_im) : acc.corr_im;
                result_reg <= SNR_MIN_Q8;
            end
            S_NORM:
            begin
                if (r_reg >= R_LIMIT)
                begin
                    r_reg  <= r_reg >> 1;
                    pr_reg <= pr_reg >> 1;
                    pi_reg <= pi_reg >> 1;
                end
            end
            S_SQR:
            begin
                sq_re_reg <= pr_reg[30:0] * pr_reg[30:0];
                sq_im_reg <= pi_reg[30:0] * pi_reg[30:0];
            end
            S_SUM:
            begin
                x_reg    <= sq_sum << 2;
                root_reg <= 64'd0;
                bit_reg  <= 64'd1 << 62;
                cnt_reg  <= 6'd0;
            end
            S_ROOT:
            begin
                // one result bit per step
                if (x_reg >= root_try)
                begin
                    x_reg    <= x_reg - root_try;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 6'd1;
            end
            S_MUL:
            begin
                p1_reg <= 48'(a) * 48'(CLAMP_NUM);
                p2_reg <= 48'(r_reg[30:0]) * 48'(CLAMP_DEN);
                p3_reg <= 57'(a) * 57'(CLAMP_SCALE);
            end
            S_SEL:
            begin
                if (clamp)
                begin
                    num_reg <= 58'(p3_reg) + 58'(r_reg[30:0]);
                    den_reg <= {r_reg[31:0], 1'b0};
                end
                else
                begin
                    num_reg <= 58'({a, 9'd0}) + 58'(r_reg[31:0] - a);
                    den_reg <= {r_reg[31:0] - a, 1'b0};
                end
                rem_reg <= 34'd0;
                q_reg   <= 58'd0;
                cnt_reg <= 6'd0;
            end
            S_DIV:
            begin
                // restoring division, one quotient bit per step
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_reg <= rem_sh - {1'b0, den_reg};
                    q_reg   <= {q_reg[56:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    q_reg   <= {q_reg[56:0], 1'b0};
                end
                num_reg <= num_reg << 1;
                cnt_reg <= cnt_reg + 6'd1;
            end
            S_SAT:
            begin
                if (q_reg >= 58'(SNR_MAX_Q8))
                begin
                    result_reg <= SNR_MAX_Q8;
                end
                else if (q_reg < 58'(SNR_MIN_Q8))
                begin
                    result_reg <= SNR_MIN_Q8;
                end
                else
                begin
                    result_reg <= q_reg[OUT_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign status.idle  = state_reg == S_IDLE;
    assign status.valid = state_reg == S_DONE;
    assign result       = result_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/halves_correlation_snr_estimator.sv =====
// halves_correlation_snr_estimator: top level of the preamble snr estimator
// depends on hcse_pkg, hcse_ram and hcse_finish
`default_nettype none
// A preamble of 2*half_length complex samples is taken one sample per transfer,
// one transfer per cycle while sample_stall is low. The first half is written into
// the sample ram; each second-half sample reads its partner back from the ram,
// the products are registered and then added into the correlation and energy
// sums. When the last sample of a preamble is taken, sample_stall goes high
// until the sums, with the last products added in, are handed to the
// finishing unit. That unit normalizes (one bit per cycle), squares and sums,
// takes the square root, forms the products and the divisor and divides, then
// saturates and offers the estimate, while the next preamble is already being
// accumulated; a preamble that ends before the unit is free waits with
// sample_stall high. The estimate is held in the unit's result register until
// its transfer. A write of half_length restarts the preamble; it must only be
// written while the block is idle.
module halves_correlation_snr_estimator #(
    parameter int MAX_HALF    = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          sample_valid,
    output logic                               sample_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_re,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_im,
    output logic                               snr_valid,
    input  wire logic                          snr_stall,
    output logic [hcse_pkg::OUT_W-1:0]         snr_estimate,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [hcse_pkg::CFG_W-1:0]    cfg_data
);
    import hcse_pkg::*;

    localparam int AW    = (MAX_HALF > 1) ? $clog2(MAX_HALF) : 1;
    localparam int LW    = $clog2(MAX_HALF + 1);
    localparam int PW    = $clog2(2 * MAX_HALF + 1);
    localparam int PRW   = 2 * SAMPLE_BITS + 1;
    // energy of 2*MAX_HALF full-scale samples reaches 2^(2*SAMPLE_BITS+log2(MAX_HALF))
    localparam int ACC_W = 2 * SAMPLE_BITS + $clog2(MAX_HALF) + 2;

    // configuration
    logic [CFG_W-1:0] half_length_reg;
    logic             cfg_xfer;
    logic [31:0]      eff32;
    logic [LW-1:0]    eff_len;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    // zero counts as one, beyond the store saturates to its depth
    always_comb
    begin
        if (half_length_reg == '0)
        begin
            eff32 = 32'd1;
        end
        else if (32'(half_length_reg) > 32'(MAX_HALF))
        begin
            eff32 = 32'(MAX_HALF);
        end
        else
        begin
            eff32 = 32'(half_length_reg);
        end
    end
    assign eff_len = eff32[LW-1:0];

    // sample position and handoff control
    logic [PW-1:0] pos_reg;
    logic          pend_reg;
    logic          in_xfer, second, last;
    logic [PW-1:0] rd_pos;
    fin_status_t   fin_status;
    logic          fin_start;

    assign sample_stall = pend_reg;
    assign in_xfer      = sample_valid && !sample_stall;
    assign second       = pos_reg >= PW'(eff_len);
    assign last         = (pos_reg + PW'(1)) == PW'({eff_len, 1'b0});
    assign rd_pos       = pos_reg - PW'(eff_len);

    // first half in ram; a read issued the cycle after a write to the same
    // entry sees the new data, so no forwarding is needed
    logic [2*SAMPLE_BITS-1:0] rd_data;

    hcse_ram #(
        .WIDTH(2 * SAMPLE_BITS),
        .DEPTH(MAX_HALF),
        .AW   (AW)
    ) u_store (
        .clk  (clk),
        .we   (in_xfer && !second),
        .waddr(pos_reg[AW-1:0]),
        .wdata({sample_re, sample_im}),
        .re   (in_xfer && second),
        .raddr(rd_pos[AW-1:0]),
        .rdata(rd_data)
    );

    // stage 1: sample waits for its stored partner
    logic                          s1_valid_reg, s1_second_reg;
    logic signed [SAMPLE_BITS-1:0] s1_re_reg, s1_im_reg;
    logic signed [SAMPLE_BITS-1:0] fr, fi;

    assign fr = $signed(rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    assign fi = $signed(rd_data[SAMPLE_BITS-1:0]);

    // stage 2: registered products
    logic                  s2_valid_reg, s2_second_reg;
    logic signed [PRW-1:0] e2_reg, cr2_reg, ci2_reg;

    // sums
    logic signed [ACC_W-1:0] energy_reg, corr_re_reg, corr_im_reg;
    acc_t                    acc;

    assign fin_start = pend_reg && !s1_valid_reg && !s2_valid_reg && fin_status.idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_length_reg <= CFG_W'(HALF_RESET);
            pos_reg         <= '0;
            pend_reg        <= 1'b0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            energy_reg      <= '0;
            corr_re_reg     <= '0;
            corr_im_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= in_xfer;
            s2_valid_reg <= s1_valid_reg;
            if (cfg_xfer)
            begin
                half_length_reg <= cfg_data;
                pos_reg         <= '0;
                energy_reg      <= '0;
                corr_re_reg     <= '0;
                corr_im_reg     <= '0;
            end
            else
            begin
                if (in_xfer)
                begin
                    pos_reg <= last ? '0 : pos_reg + PW'(1);
                    if (last)
                    begin
                        pend_reg <= 1'b1;
                    end
                end
                if (fin_start)
                begin
                    // sums go to the finishing unit, next preamble starts clean
                    pend_reg    <= 1'b0;
                    energy_reg  <= '0;
                    corr_re_reg <= '0;
                    corr_im_reg <= '0;
                end
                else if (s2_valid_reg)
                begin
                    energy_reg <= energy_reg + ACC_W'(e2_reg);
                    if (s2_second_reg)
                    begin
                        corr_re_reg <= corr_re_reg + ACC_W'(cr2_reg);
                        corr_im_reg <= corr_im_reg + ACC_W'(ci2_reg);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_second_reg <= second;
        s1_re_reg     <= sample_re;
        s1_im_reg     <= sample_im;
        s2_second_reg <= s1_second_reg;
        e2_reg        <= PRW'(s1_re_reg) * PRW'(s1_re_reg)
                       + PRW'(s1_im_reg) * PRW'(s1_im_reg);
        cr2_reg       <= PRW'(fr) * PRW'(s1_re_reg) + PRW'(fi) * PRW'(s1_im_reg);
        ci2_reg       <= PRW'(fr) * PRW'(s1_im_reg) - PRW'(fi) * PRW'(s1_re_reg);
    end

    assign acc.corr_re = 64'(corr_re_reg);
    assign acc.corr_im = 64'(corr_im_reg);
    assign acc.energy  = 64'(energy_reg);

    hcse_finish u_finish (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (fin_start),
        .acc      (acc),
        .out_stall(snr_stall),
        .status   (fin_status),
        .result   (snr_estimate)
    );

    assign snr_valid = fin_status.valid;

endmodule
`default_nettype wire

// ===== hw/rtl/hcse_checker.sv =====
// hcse_checker: port-level assertions for halves_correlation_snr_estimator, with bind
// depends on hcse_pkg (output width and saturation bounds)
`default_nettype none
module hcse_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      sample_valid,
    input wire logic                      sample_stall,
    input wire logic                      snr_valid,
    input wire logic                      snr_stall,
    input wire logic [hcse_pkg::OUT_W-1:0] snr_estimate
);
    import hcse_pkg::*;

    // a stalled result stays and holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        snr_valid && snr_stall |=> snr_valid && $stable(snr_estimate))
        else $error("stalled result changed");

    // every estimate lies in the saturation range
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        snr_valid |-> snr_estimate >= SNR_MIN_Q8 && snr_estimate <= SNR_MAX_Q8)
        else $error("estimate out of range");

    // input stall only follows a sample transfer
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sample_stall) |-> $past(sample_valid && !sample_stall))
        else $error("stall without a preceding transfer");

endmodule

bind halves_correlation_snr_estimator hcse_checker u_hcse_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .snr_valid   (snr_valid),
    .snr_stall   (snr_stall),
    .snr_estimate(snr_estimate)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for halves_correlation_snr_estimator
// depends on hcse_pkg and the estimator rtl; predicts each snr estimate from the samples
`timescale 1ns / 1ps
module tb_top;
    import hcse_pkg::*;

    localparam int MAX_HALF = 256;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   sample_valid = 1'b0;
    logic                   sample_stall;
    logic signed [15:0]     sample_re = '0;
    logic signed [15:0]     sample_im = '0;
    logic                   snr_valid;
    logic                   snr_stall = 1'b0;
    logic [OUT_W-1:0]       snr_estimate;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data = '0;

    // idle percentages for sender and receiver
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // predictor state
    logic signed [15:0]     half_re [MAX_HALF];
    logic signed [15:0]     half_im [MAX_HALF];
    logic [CFG_W-1:0]       half_reg = CFG_W'(HALF_RESET);
    int unsigned            position = 0;
    longint                 corr_re_sum = 0;
    longint                 corr_im_sum = 0;
    longint                 energy_sum = 0;

    logic [OUT_W-1:0]       snr_expected [$];
    int unsigned            errors = 0;
    int unsigned            estimates_seen = 0;
    int unsigned            samples_sent = 0;

    halves_correlation_snr_estimator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_re    (sample_re),
        .sample_im    (sample_im),
        .snr_valid    (snr_valid),
        .snr_stall    (snr_stall),
        .snr_estimate (snr_estimate),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int unsigned eff_half();
        if (half_reg == 0)
            return 1;
        if (half_reg > MAX_HALF)
            return MAX_HALF;
        return half_reg;
    endfunction

    // bitwise integer square root
    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    // snr = m/(1-m) with m = 2|P|/R, clamped and saturated
    function automatic logic [OUT_W-1:0] snr_from_sums();
        longint unsigned r, pr, pi, a, q, d;
        int unsigned k;
        if (energy_sum <= 0)
            return SNR_MIN_Q8;
        k = 0;
        r = energy_sum;
        while ((r >> k) >= (64'd1 << 31))
            k++;
        pr = (corr_re_sum < 0 ? -corr_re_sum : corr_re_sum);
        pi = (corr_im_sum < 0 ? -corr_im_sum : corr_im_sum);
        pr >>= k;
        pi >>= k;
        r >>= k;
        a = int_sqrt(4 * (pr * pr + pi * pi));
        if (64'(CLAMP_NUM) * a >= 64'(CLAMP_DEN) * r)
            q = (64'(CLAMP_SCALE) * a + r) / (2 * r);
        else
        begin
            d = r - a;
            q = (a * 512 + d) / (2 * d);
        end
        if (q < SNR_MIN_Q8)
            q = SNR_MIN_Q8;
        if (q > SNR_MAX_Q8)
            q = SNR_MAX_Q8;
        return q[OUT_W-1:0];
    endfunction

    function automatic void clear_sums();
        position = 0;
        corr_re_sum = 0;
        corr_im_sum = 0;
        energy_sum = 0;
    endfunction

    // advance the predictor by one accepted sample
    function automatic void predict_sample(logic signed [15:0] re, logic signed [15:0] im);
        int unsigned len;
        int unsigned idx;
        longint fr, fi, sr, si;
        len = eff_half();
        sr = re;
        si = im;
        energy_sum += sr * sr + si * si;
        if (position < len)
        begin
            half_re[position] = re;
            half_im[position] = im;
        end
        else
        begin
            idx = (position - len) % MAX_HALF;
            fr = half_re[idx];
            fi = half_im[idx];
            corr_re_sum += fr * sr + fi * si;
            corr_im_sum += fr * si - fi * sr;
        end
        position++;
        if (position >= 2 * len)
        begin
            snr_expected.push_back(snr_from_sums());
            clear_sums();
        end
    endfunction

    // receiver: random stall, compare each estimate transfer
    always @(posedge clk)
    begin
        if (rst_n && snr_valid && !snr_stall)
        begin
            estimates_seen++;
            if (snr_expected.size() == 0)
            begin
                $error("snr_estimate: unexpected transfer, actual %0d", snr_estimate);
                errors++;
            end
            else
            begin
                if (snr_estimate !== snr_expected[0])
                begin
                    $error("snr_estimate: expected %0d actual %0d",
                           snr_expected[0], snr_estimate);
                    errors++;
                end
                void'(snr_expected.pop_front());
            end
        end
        snr_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // one sample transfer, with a random idle gap before it; valid stays high
    // after the transfer until the next gap or drain
    task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_re <= re;
        sample_im <= im;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        predict_sample(re, im);
        samples_sent++;
    endtask

    // wait for every estimate, then let the finishing unit drain
    task automatic wait_drained();
        sample_valid <= 1'b0;
        while (snr_expected.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // write half_length while idle; restarts the preamble
    task automatic write_half(logic [CFG_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        half_reg = value;
        clear_sums();
    endtask

    task automatic send_preamble(int unsigned noise_amp, bit full_scale);
        int unsigned len;
        logic signed [15:0] base_re [MAX_HALF];
        logic signed [15:0] base_im [MAX_HALF];
        logic signed [15:0] nre, nim;
        len = eff_half();
        for (int unsigned i = 0; i < len; i++)
        begin
            base_re[i] = full_scale ? 16'sh8000 : 16'($urandom);
            base_im[i] = full_scale ? 16'sh7fff : 16'($urandom);
            send_sample(base_re[i], base_im[i]);
        end
        for (int unsigned i = 0; i < len; i++)
        begin
            nre = base_re[i] + 16'($signed($urandom_range(2 * noise_amp)) - noise_amp);
            nim = base_im[i] + 16'($signed($urandom_range(2 * noise_amp)) - noise_amp);
            send_sample(nre, nim);
        end
    endtask

    task automatic set_idle(int unsigned phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
        endcase
    endtask

    // extremes, zero energy, identical halves and short lengths
    task automatic test_directed();
        write_half(9'd1);
        send_sample(16'sh0000, 16'sh0000);   // zero energy gives minimum
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'sh7fff, 16'sh8000);   // identical halves: clamp path
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh8000, 16'sh7fff);   // opposite halves
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh0001, 16'shffff);
        send_sample(16'shffff, 16'sh0001);
        write_half(9'd0);                    // zero length acts as one
        send_sample(16'sh1234, 16'shedcb);
        send_sample(16'sh1230, 16'shedc0);
        write_half(9'd3);
        send_preamble(0, 1'b1);
        write_half(9'd2);
        send_sample(16'sh4000, 16'sh0000);   // write mid-preamble restarts
        write_half(9'd2);
        send_preamble(300, 1'b0);
    endtask

    // random preambles over several lengths and idle phases
    task automatic test_random_preambles();
        logic [CFG_W-1:0] lens [6] = '{9'd1, 9'd4, 9'd7, 9'd16, 9'd5, 9'd2};
        int unsigned amp;
        for (int unsigned phase = 0; phase < 8; phase++)
        begin
            set_idle(phase);
            write_half(lens[phase % 6]);
            for (int unsigned p = 0; p < 5; p++)
            begin
                case ($urandom_range(3))
                    0: amp = 0;
                    1: amp = $urandom_range(50);
                    2: amp = $urandom_range(3000);
                    default: amp = 32767;
                endcase
                send_preamble(amp, 1'b0);
            end
        end
        // noise across several preamble boundaries, ending in a partial preamble
        for (int unsigned i = 0; i < 37; i++)
            send_sample(16'($urandom), 16'($urandom));
    endtask

    // largest lengths: a value above the maximum that saturates to it, then the reset length of 32
    task automatic test_long_lengths();
        set_idle(3);
        write_half(9'd511);
        send_preamble(100, 1'b0);
        set_idle(0);
        write_half(9'd32);
        send_preamble(1000, 1'b0);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_idle(0);
        send_preamble(10, 1'b0);   // reset length of 32
        test_directed();
        test_random_preambles();
        test_long_lengths();
        set_idle(0);
        wait_drained();
        $display("covered %0d samples and %0d estimates over half lengths 0 to 511",
                 samples_sent, estimates_seen);
        $display("with zero energy, full scale, clamped and noisy preambles");
        if (errors == 0 && snr_expected.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
